// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants, result codes and control structs of the frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int FRAME_BYTES    = 25;
    localparam int ADDR_W         = $clog2(FRAME_BYTES);
    localparam int FLAGS_POS      = 23;
    localparam int CHAN_FIRST_POS = 1;
    localparam int CHAN_LAST_POS  = 22;
    localparam int NUM_CHANNELS   = 16;
    localparam int CH_IDX_W       = $clog2(NUM_CHANNELS);
    localparam int CHAN_W         = 11;
    localparam int BYTE_W         = 8;
    // bit accumulator holds at most one byte on top of a partial channel
    localparam int ACC_W          = CHAN_W - 1 + BYTE_W;
    localparam int BITS_W         = $clog2(ACC_W + 1);
    localparam int STATUS_W       = 2;

    localparam logic [STATUS_W-1:0] ST_CHAN      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISC      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FRAME_ERR = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h0f;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h00;

    localparam int                CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;

    // frame-complete event from the collector to the unpacker
    typedef struct packed {
        logic              go;
        logic              bad;
        logic              disc;
        logic [BYTE_W-1:0] flags;
    } t_frame_evt;

    // unpacker status back to the collector
    typedef struct packed {
        logic running;
        logic out_pending;
    } t_unp_status;

endpackage

// File: rtl/sfr_rx_if.sv
// ----------------------------------------------------------------------------
// sfr_rx_if
// received byte channel, valid/ready transfer
// ----------------------------------------------------------------------------
interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/sfr_res_if.sv
// ----------------------------------------------------------------------------
// sfr_res_if
// decoded result channel, valid/ready transfer
// ----------------------------------------------------------------------------
interface sfr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [7:0]  flags_byte;
    logic        last;

    modport source (output valid, output status, output channel_index,
                    output channel_value, output flags_byte, output last,
                    input ready);
    modport sink   (input valid, input status, input channel_index,
                    input channel_value, input flags_byte, input last,
                    output ready);
endinterface

// File: rtl/sbus_frame_receiver.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// frame receiver for 25-byte serial frames carrying sixteen 11-bit channels
// ----------------------------------------------------------------------------
// usage:
//   i_rx takes one received byte per transfer; o_res gives the decoded results
//   the config port writes start_byte (index 0) and end_byte (index 1), with the
//   low 8 bits of the data kept
//   while unsynchronized every byte other than start_byte is dropped; a start
//   byte opens a frame and the next 24 bytes are stored in the frame ram
//   the final byte of a frame checks start and end bytes: a bad frame gives a
//   single frame error result, a nonzero flags byte a single disconnected result,
//   both valid in the cycle right after the final transfer
//   a good frame is unpacked from the ram one byte per read, 22 reads in all;
//   each read goes through the single ram read port and its byte is then
//   appended to the bit accumulator, which takes one byte or gives one channel
//   at a time
//   i_rx is held off while a frame is unpacked, and the final byte of a frame
//   waits until the output register is empty
//   a stall on o_res holds the output register and pauses the unpacker
//   reset clears sync state, the byte count, the output register and the
//   config registers; the frame ram is not cleared, every entry is written
//   before it is read
// ----------------------------------------------------------------------------
module sbus_frame_receiver
    import sfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfr_rx_if.sink                i_rx,
    sfr_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0]     i_cfg_data
);

    // config registers
    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;

    // frame collection state
    logic              r_synced, n_synced;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_first, n_first;   // byte at frame position zero
    logic [BYTE_W-1:0] r_flags, n_flags;   // byte at the flags position

    t_frame_evt        evt;
    t_unp_status       unp_status;
    logic              rx_xfer;
    logic              final_byte;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_END_BYTE:   r_end_byte   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // final byte of a frame waits for an empty output register
    assign final_byte = r_synced && (r_cnt == ADDR_W'(FRAME_BYTES - 1));
    assign i_rx.ready = !unp_status.running && !(final_byte && unp_status.out_pending);
    assign rx_xfer    = i_rx.valid && i_rx.ready;

    always_comb begin
        n_synced  = r_synced;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_flags   = r_flags;
        wr_en     = 1'b0;
        wr_addr   = r_cnt;
        evt.go    = 1'b0;
        evt.bad   = (r_first != r_start_byte) || (i_rx.rx_byte != r_end_byte);
        evt.disc  = (r_flags != '0);
        evt.flags = r_flags;

        if (rx_xfer) begin
            if (!r_synced) begin
                // hunt for the start byte, it becomes frame position zero
                if (i_rx.rx_byte == r_start_byte) begin
                    n_synced = 1'b1;
                    n_first  = i_rx.rx_byte;
                    wr_en    = 1'b1;
                    wr_addr  = '0;
                    n_cnt    = ADDR_W'(1);
                end
            end else begin
                wr_en = 1'b1;
                if (r_cnt == ADDR_W'(FLAGS_POS)) begin
                    n_flags = i_rx.rx_byte;
                end
                if (final_byte) begin
                    evt.go   = 1'b1;
                    n_synced = 1'b0;
                    n_cnt    = '0;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_synced <= n_synced;
            r_cnt    <= n_cnt;
        end
        r_first <= n_first;
        r_flags <= n_flags;
    end

    sfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rx.rx_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    sfr_unpacker u_unpacker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (evt),
        .o_status  (unp_status),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res     (o_res)
    );

    // ram is never written while a frame is read back
    a_no_wr_during_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unp_status.running |-> !wr_en)
        else $error("sbus_frame_receiver: frame ram written while unpacking");

    // byte count stays inside the frame
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ADDR_W'(FRAME_BYTES - 1))
        else $error("sbus_frame_receiver: byte count out of range");

    // count is zero whenever the receiver is hunting for a start byte
    a_unsynced_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_synced |-> r_cnt == '0)
        else $error("sbus_frame_receiver: count not cleared out of sync");

endmodule

// File: rtl/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sfr_unpacker.sv
// ----------------------------------------------------------------------------
// sfr_unpacker
// reads the stored frame byte by byte and emits results through an
// output register
// ----------------------------------------------------------------------------
module sfr_unpacker
    import sfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_frame_evt         i_evt,
    output t_unp_status        o_status,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_rd_addr,
    input  logic [BYTE_W-1:0]  i_rd_data,
    sfr_res_if.source          o_res
);

    localparam logic U_IDLE = 1'b0;
    localparam logic U_RUN  = 1'b1;

    logic                r_state, n_state;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [BITS_W-1:0]   r_bits, n_bits;
    logic [CH_IDX_W-1:0] r_ch, n_ch;
    logic [BYTE_W-1:0]   r_flags, n_flags;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [CH_IDX_W-1:0] r_out_index, n_out_index;
    logic [CHAN_W-1:0]   r_out_value, n_out_value;
    logic [BYTE_W-1:0]   r_out_flags, n_out_flags;
    logic                r_out_last, n_out_last;

    logic slot_free;
    logic have_chan;
    logic bytes_left;
    logic rd_en;

    assign slot_free  = !r_out_valid || o_res.ready;
    assign have_chan  = r_bits >= BITS_W'(CHAN_W);
    assign bytes_left = r_addr <= ADDR_W'(CHAN_LAST_POS);
    assign rd_en      = (r_state == U_RUN) && !r_pend && !have_chan && bytes_left;

    always_comb begin
        n_state      = r_state;
        n_pend       = 1'b0;
        n_addr       = r_addr;
        n_acc        = r_acc;
        n_bits       = r_bits;
        n_ch         = r_ch;
        n_flags      = r_flags;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_value  = r_out_value;
        n_out_flags  = r_out_flags;
        n_out_last   = r_out_last;

        unique case (r_state)
            U_IDLE: begin
                if (i_evt.go) begin
                    if (i_evt.bad || i_evt.disc) begin
                        n_out_valid  = 1'b1;
                        n_out_status = i_evt.bad ? ST_FRAME_ERR : ST_DISC;
                        n_out_index  = '0;
                        n_out_value  = '0;
                        n_out_flags  = i_evt.flags;
                        n_out_last   = 1'b1;
                    end else begin
                        n_state = U_RUN;
                        n_addr  = ADDR_W'(CHAN_FIRST_POS);
                        n_acc   = '0;
                        n_bits  = '0;
                        n_ch    = '0;
                        n_flags = i_evt.flags;
                    end
                end
            end
            U_RUN: begin
                if (r_pend) begin
                    // append the fetched byte above the bits still held
                    n_acc  = r_acc | (ACC_W'(i_rd_data) << r_bits);
                    n_bits = r_bits + BITS_W'(BYTE_W);
                end else if (have_chan) begin
                    if (slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_CHAN;
                        n_out_index  = r_ch;
                        n_out_value  = r_acc[CHAN_W-1:0];
                        n_out_flags  = r_flags;
                        n_out_last   = (r_ch == CH_IDX_W'(NUM_CHANNELS - 1));
                        n_acc        = r_acc >> CHAN_W;
                        n_bits       = r_bits - BITS_W'(CHAN_W);
                        n_ch         = r_ch + CH_IDX_W'(1);
                        if (r_ch == CH_IDX_W'(NUM_CHANNELS - 1)) begin
                            n_state = U_IDLE;
                        end
                    end
                end else if (bytes_left) begin
                    n_pend = 1'b1;
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= U_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_acc        <= n_acc;
        r_bits       <= n_bits;
        r_ch         <= n_ch;
        r_flags      <= n_flags;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_value  <= n_out_value;
        r_out_flags  <= n_out_flags;
        r_out_last   <= n_out_last;
    end

    assign o_rd_en              = rd_en;
    assign o_rd_addr            = r_addr;
    assign o_status.running     = (r_state == U_RUN);
    assign o_status.out_pending = r_out_valid;

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.channel_index = r_out_index;
    assign o_res.channel_value = r_out_value;
    assign o_res.flags_byte    = r_out_flags;
    assign o_res.last          = r_out_last;

    // bit accumulator never overflows its width
    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == U_RUN |-> r_bits <= BITS_W'(ACC_W))
        else $error("sfr_unpacker: bit count overflow");

    // a new frame never arrives while the previous one is still being unpacked
    a_evt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.go |-> (r_state == U_IDLE) && !r_out_valid)
        else $error("sfr_unpacker: frame event while busy");

    // every read issued is absorbed in the following cycle
    a_read_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_pend)
        else $error("sfr_unpacker: read data lost");

    // the last channel result carries the highest channel number
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last && (r_out_status == ST_CHAN)
            |-> r_out_index == CH_IDX_W'(NUM_CHANNELS - 1))
        else $error("sfr_unpacker: last flag on wrong channel");

endmodule

// File: tb/sbus_frame_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver_test
// checks decoded channel, disconnect and frame error results against typed-in values
// for most directed frames and against a cycle-free predictor of the frame receiver
// otherwise, with directed frames first, then random traffic under several start/end
// byte settings, random stalls on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module sbus_frame_receiver_test;
    import sfr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 26;
    localparam int SETTLE       = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_BYTES  = 25;
    localparam int NUM_PHASES   = 3;
    localparam int NUM_ROWS     = 7;
    localparam int REPORT_MAX   = 10;

    // one decoded result as it appears on the result channel
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CH_IDX_W-1:0] idx;
        logic [CHAN_W-1:0]   value;
        logic [BYTE_W-1:0]   flags;
        logic                last;
    } t_res;

    // directed frame recipe: noise bytes ahead of the frame, payload fill,
    // flags and tail byte; tab marks rows whose results are typed in here
    typedef struct packed {
        logic [3:0]          lead_cnt;
        logic [BYTE_W-1:0]   lead_val;
        logic [BYTE_W-1:0]   fill;
        logic                fill_rnd;
        logic [BYTE_W-1:0]   flags;
        logic [BYTE_W-1:0]   tail;
        logic                tab;
        logic [STATUS_W-1:0] tab_status;
        logic [CHAN_W-1:0]   tab_value;
    } t_frame_row;

    // rows run with the reset setting: start 0x0f, end 0x00
    localparam t_frame_row DIR_ROWS [NUM_ROWS] = '{
        // noise first, all-zero payload: every channel zero
        '{4'd3, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, ST_CHAN,      11'h000},
        // all-ones payload: every channel at full scale
        '{4'd0, 8'h00, 8'hff, 1'b0, 8'h00, 8'h00, 1'b1, ST_CHAN,      11'h7ff},
        // lowest nonzero flags: disconnected
        '{4'd0, 8'h00, 8'h55, 1'b0, 8'h01, 8'h00, 1'b1, ST_DISC,      11'h000},
        // all flag bits set: disconnected
        '{4'd1, 8'hf0, 8'haa, 1'b0, 8'hff, 8'h00, 1'b1, ST_DISC,      11'h000},
        // wrong tail byte: frame error
        '{4'd0, 8'h00, 8'h0f, 1'b0, 8'h00, 8'hff, 1'b1, ST_FRAME_ERR, 11'h000},
        // wrong tail with flags set: frame error wins, flags still carried
        '{4'd0, 8'h00, 8'h00, 1'b1, 8'h80, 8'h01, 1'b1, ST_FRAME_ERR, 11'h000},
        // payload made of start byte values must not resync
        '{4'd1, 8'h0e, 8'h0f, 1'b0, 8'h00, 8'h00, 1'b0, ST_CHAN,      11'h000}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0] i_cfg_data;

    sfr_rx_if  rx_ch();
    sfr_res_if res_ch();

    sbus_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state: register copies, sync flag, byte position, frame bytes
    logic [BYTE_W-1:0] cfg_start;
    logic [BYTE_W-1:0] cfg_end;
    bit                synced;
    int                byte_cnt;
    logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
    t_res              frame_out [NUM_CHANNELS];

    t_res pending_results [$];
    int   mismatch_cnt;
    int   bytes_sent;
    int   stall_cnt;
    bit   tab_mode;     // results of this frame were queued from the table
    bit   calm;         // no random idling on either side
    bit   hold_req;
    bit   hold_used;
    int   hold_left;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor: feed one accepted byte, returns how many results it causes
    // (left in frame_out)
    // ------------------------------------------------------------------------
    function automatic int decode_byte(input logic [BYTE_W-1:0] b);
        logic [23:0]       win;
        logic [BYTE_W-1:0] flags;
        int                bitpos;
        int                pos;
        int                k;
        if (!synced) begin
            // unsynchronized: only the start byte opens a frame
            if (b != cfg_start)
                return 0;
            synced   = 1'b1;
            byte_cnt = 0;
        end
        frame_mem[byte_cnt] = b;
        if (byte_cnt < FRAME_BYTES - 1) begin
            byte_cnt++;
            return 0;
        end
        synced   = 1'b0;
        byte_cnt = 0;
        flags    = frame_mem[FLAGS_POS];
        if (frame_mem[0] != cfg_start || frame_mem[FRAME_BYTES-1] != cfg_end) begin
            frame_out[0] = '{ST_FRAME_ERR, '0, '0, flags, 1'b1};
            return 1;
        end
        if (flags != '0) begin
            frame_out[0] = '{ST_DISC, '0, '0, flags, 1'b1};
            return 1;
        end
        // channel k is bits 11k..11k+10 of the little-endian payload stream
        for (k = 0; k < NUM_CHANNELS; k++) begin
            bitpos = CHAN_W * k;
            pos    = CHAN_FIRST_POS + bitpos / 8;
            win    = {frame_mem[pos+2], frame_mem[pos+1], frame_mem[pos]};
            frame_out[k] = '{ST_CHAN, CH_IDX_W'(k), CHAN_W'(win >> (bitpos % 8)),
                             flags, (k == NUM_CHANNELS - 1)};
        end
        return NUM_CHANNELS;
    endfunction

    // ------------------------------------------------------------------------
    // byte sender: drives at the falling edge, valid stays up from one
    // transfer to the next, but is dropped during random idles and by
    // rx_idle before a pause
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int n;
        int i;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
        n = decode_byte(b);
        if (!tab_mode)
            for (i = 0; i < n; i++)
                pending_results.push_back(frame_out[i]);
    endtask

    task automatic rx_idle();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
    endtask

    // start byte, 22 payload bytes, flags, tail
    task automatic send_frame(input logic [BYTE_W-1:0] fill, input bit rnd,
                              input logic [BYTE_W-1:0] flags,
                              input logic [BYTE_W-1:0] tail);
        int i;
        send_byte(cfg_start);
        for (i = CHAN_FIRST_POS; i <= CHAN_LAST_POS; i++)
            send_byte(rnd ? BYTE_W'($urandom_range(0, 255)) : fill);
        send_byte(flags);
        send_byte(tail);
    endtask

    // finish an open frame with random bytes
    task automatic close_frame();
        while (synced)
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // sender stops until every expected result is in, then lets the block settle
    task automatic wait_drained();
        rx_idle();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_START_BYTE)
            cfg_start = data;
        else
            cfg_end = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed frames with random content, some noise and garbage
    task automatic random_traffic(input int budget);
        int first;
        int roll;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] tail;
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                // line noise, may open a frame by chance
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                close_frame();
            end else if (roll < 25) begin
                // start byte followed by garbage, usually a frame error
                send_byte(cfg_start);
                close_frame();
            end else begin
                flags = ($urandom_range(0, 99) < 70) ? '0 : BYTE_W'($urandom_range(1, 255));
                tail  = ($urandom_range(0, 99) < 85) ? cfg_end
                                                      : BYTE_W'($urandom_range(0, 255));
                if ($urandom_range(0, 9) == 0)
                    send_frame($urandom_range(0, 1) ? 8'hff : 8'h00, 1'b0, flags, tail);
                else
                    send_frame('0, 1'b1, flags, tail);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result receiver: ready at the falling edge, random stalls, one long
    // hold-off counted here so the block fills up and stalls the byte input
    // ------------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b0;
        hold_used    = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // result checker: each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.status, res_ch.channel_index, res_ch.channel_value,
                    res_ch.flags_byte, res_ch.last};
            if (pending_results.size() == 0) begin
                if (mismatch_cnt < REPORT_MAX)
                    $display("unexpected result: status %0d idx %0d value 0x%03h flags 0x%02h last %0d",
                             got.status, got.idx, got.value, got.flags, got.last);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.idx !== want.idx ||
                    got.value !== want.value || got.flags !== want.flags ||
                    got.last !== want.last) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("mismatch: expected status %0d idx %0d value 0x%03h flags 0x%02h last %0d, got status %0d idx %0d value 0x%03h flags 0x%02h last %0d",
                                 want.status, want.idx, want.value, want.flags, want.last,
                                 got.status, got.idx, got.value, got.flags, got.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("sbus_frame_receiver test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        t_frame_row row;
        t_res       tab_res;
        logic [BYTE_W-1:0] phase_start [NUM_PHASES];
        logic [BYTE_W-1:0] phase_end   [NUM_PHASES];
        int r;
        int k;
        int p;

        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START_BYTE;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        cfg_start     = START_BYTE_RST;
        cfg_end       = END_BYTE_RST;
        synced        = 1'b0;
        byte_cnt      = 0;
        mismatch_cnt  = 0;
        bytes_sent    = 0;
        stall_cnt     = 0;
        tab_mode      = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;

        // settings per random phase: extremes, start equal to end, random
        phase_start = '{8'h00, 8'ha5, BYTE_W'($urandom_range(0, 255))};
        phase_end   = '{8'hff, 8'ha5, BYTE_W'($urandom_range(0, 255))};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // long receiver hold-off over the first frames while bytes keep coming
        hold_req = 1'b1;

        // directed frames at the reset setting
        for (r = 0; r < NUM_ROWS; r++) begin
            row = DIR_ROWS[r];
            repeat (row.lead_cnt) send_byte(row.lead_val);
            if (row.tab) begin
                if (row.tab_status == ST_CHAN) begin
                    for (k = 0; k < NUM_CHANNELS; k++) begin
                        tab_res = '{ST_CHAN, CH_IDX_W'(k), row.tab_value, 8'h00,
                                    (k == NUM_CHANNELS - 1)};
                        pending_results.push_back(tab_res);
                    end
                end else begin
                    tab_res = '{row.tab_status, '0, '0, row.flags, 1'b1};
                    pending_results.push_back(tab_res);
                end
            end
            tab_mode = row.tab;
            send_frame(row.fill, row.fill_rnd, row.flags, row.tail);
            tab_mode = 1'b0;
        end
        wait_drained();

        // random phases, registers only rewritten once everything has drained
        for (p = 0; p < NUM_PHASES; p++) begin
            cfg_write(CFG_START_BYTE, phase_start[p]);
            cfg_write(CFG_END_BYTE, phase_end[p]);
            calm = (p == 1);        // one phase with no idling at all
            random_traffic(PHASE_BYTES);
            close_frame();
            wait_drained();
            calm = 1'b0;
        end

        mismatch_cnt += pending_results.size();
        if (mismatch_cnt == 0)
            $display("sbus_frame_receiver test passed");
        else
            $display("sbus_frame_receiver test failed");
        $finish;
    end

endmodule
